### rtl/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared types and constants for the NOR flash array model: field widths,
// default geometry, request codes and fixed data patterns.
// ----------------------------------------------------------------------------
package nfa_pkg;

    // Field widths of one request word and one result word
    localparam int OP_W     = 3;
    localparam int SECTOR_W = 8;
    localparam int OFFSET_W = 16;
    localparam int COUNT_W  = 8;
    localparam int WORD_W   = 32;
    localparam int ANSWER_W = 16;

    // Default array geometry
    localparam int NUM_SECTORS_DEF  = 16;
    localparam int SECTOR_BYTES_DEF = 256;

    // Fixed patterns
    localparam logic [WORD_W-1:0]   ERASED_WORD = 32'hFFFF_FFFF;
    localparam logic [7:0]          BYTE_MASK   = 8'hFF;
    localparam logic [ANSWER_W-1:0] ANSWER_MAX  = 16'hFFFF;

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_READ      = 3'd0,
        OP_PROG_BYTE = 3'd1,
        OP_PROG_WORD = 3'd2,
        OP_ERASE     = 3'd3,
        OP_SIZE      = 3'd4,
        OP_FIND      = 3'd5
    } t_op;

endpackage

### rtl/nor_flash_array_model_core.sv
// ----------------------------------------------------------------------------
// nor_flash_array_model_core
// NOR flash array of uniform sectors: word read, byte/word program that can
// only clear bits, sector erase, run-size query and sector lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on i_in_valid/o_in_ready, result words leave on
//   o_out_valid/i_out_ready; every request gives exactly one result.
//   The array is one single-port-write memory with a registered read port.
//   Requests are handled one at a time:
//     read, program, size query,
//     rejected erase, unused op : memory read, then modify/write
//     erase                      : one word written per cycle across the
//                                  sector, then the result is evaluated
//     find                       : the offset is scaled to sectors
//                                  by a reciprocal multiply on acceptance
//   A new request is taken the cycle after the previous result is loaded
//   into the output register, even if that word has not been taken yet.
//   If the output register is still full when a result is ready, the block
//   holds that result internally until the receiver drains the register.
//   After reset the array is swept to all ones, one word per cycle across
//   the whole array; o_in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module nor_flash_array_model_core #(
    parameter int NUM_SECTORS  = nfa_pkg::NUM_SECTORS_DEF,
    parameter int SECTOR_BYTES = nfa_pkg::SECTOR_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [nfa_pkg::OP_W-1:0]     i_op,
    input  logic [nfa_pkg::SECTOR_W-1:0] i_sector,
    input  logic [nfa_pkg::OFFSET_W-1:0] i_offset,
    input  logic [nfa_pkg::COUNT_W-1:0]  i_count,
    input  logic [nfa_pkg::WORD_W-1:0]   i_data,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_ok,
    output logic [nfa_pkg::WORD_W-1:0]   o_read_data,
    output logic [nfa_pkg::ANSWER_W-1:0] o_answer
);
    import nfa_pkg::*;

    localparam int WPS         = SECTOR_BYTES / 4;
    localparam int ARRAY_WORDS = NUM_SECTORS * WPS;
    localparam int AW          = $clog2(ARRAY_WORDS);
    localparam int EW          = $clog2(WPS);
    localparam int SW          = SECTOR_W + 2;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_ERASE = 5'b01000,
        S_DIV   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr, n_clr;
    logic [EW-1:0]        r_epos, n_epos;
    logic                 r_out_valid, n_out_valid;

    // captured request
    logic [OP_W-1:0]      r_op;
    logic [SECTOR_W-1:0]  r_sector;
    logic [OFFSET_W-1:0]  r_offset;
    logic [COUNT_W-1:0]   r_count;
    logic [WORD_W-1:0]    r_data;
    logic [AW-1:0]        r_addr;
    logic [AW-1:0]        r_base;

    // result register
    logic                 r_ok;
    logic [WORD_W-1:0]    r_rd;
    logic [ANSWER_W-1:0]  r_ans;

    // array memory
    logic [WORD_W-1:0]    r_mem [ARRAY_WORDS];
    logic [WORD_W-1:0]    r_mem_q;

    logic                 w_accept;
    logic                 w_sec_ok_in;
    logic [31:0]          w_base_full;
    logic [31:0]          w_idx_full;
    logic                 w_out_load;
    logic                 w_div_done;
    logic [OFFSET_W-1:0]  w_quo;

    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [WORD_W-1:0]    w_wr_data;

    logic                 w_sec_ok;
    logic                 w_in_sector;
    logic                 w_aligned;
    logic [1:0]           w_sh;
    logic [7:0]           w_cur_byte;
    logic [7:0]           w_d;
    logic [WORD_W-1:0]    w_byte_word;
    logic [SW-1:0]        w_run;
    logic [31:0]          w_size;
    logic [OFFSET_W:0]    w_sum;
    logic [OFFSET_W:0]    w_found;
    logic                 w_prog_ok;
    logic [WORD_W-1:0]    w_new_word;
    logic                 w_ok;
    logic [WORD_W-1:0]    w_rd;
    logic [ANSWER_W-1:0]  w_ans;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;

    // word index of the request and base of its sector
    assign w_sec_ok_in = ({1'b0, i_sector} < (SECTOR_W + 1)'(NUM_SECTORS));
    assign w_base_full = 32'(i_sector) * 32'(WPS);
    assign w_idx_full  = w_base_full + 32'(i_offset[OFFSET_W-1:2]);

    // find: offset to sector count
    nfa_div #(
        .DIVISOR    (SECTOR_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && (i_op == OP_FIND)),
        .i_dividend (i_offset),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // result can be loaded when the output register is free or draining
    assign w_out_load = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // request evaluation on the word read back from the array
    always_comb begin
        w_sec_ok    = ({1'b0, r_sector} < (SECTOR_W + 1)'(NUM_SECTORS));
        w_in_sector = (32'(r_offset) < 32'(SECTOR_BYTES));
        w_aligned   = (r_offset[1:0] == 2'b00);
        w_sh        = r_offset[1:0];
        w_cur_byte  = r_mem_q[8*w_sh +: 8];
        w_d         = r_data[7:0] & BYTE_MASK;
        for (int k = 0; k < 4; k++) begin
            w_byte_word[8*k +: 8] = (2'(k) == w_sh) ? w_d : r_mem_q[8*k +: 8];
        end
        w_run   = SW'(r_sector) + SW'(r_count);
        w_size  = 32'(r_count) * 32'(SECTOR_BYTES);
        w_sum   = (OFFSET_W + 1)'(r_sector) + (OFFSET_W + 1)'(w_quo);
        w_found = (w_sum > (OFFSET_W + 1)'(NUM_SECTORS))
                  ? (OFFSET_W + 1)'(NUM_SECTORS) : w_sum;
        if (!w_sec_ok) begin
            w_found = (OFFSET_W + 1)'(r_sector);
        end

        w_prog_ok  = 1'b0;
        w_new_word = r_mem_q;
        w_ok       = 1'b0;
        w_rd       = '0;
        w_ans      = '0;
        case (r_op)
            OP_READ: begin
                w_ok = w_sec_ok & w_in_sector & w_aligned;
                w_rd = w_ok ? r_mem_q : '0;
            end
            OP_PROG_BYTE: begin
                w_prog_ok  = w_sec_ok & w_in_sector & ((w_cur_byte & w_d) == w_d);
                w_new_word = w_byte_word;
                w_ok       = w_prog_ok;
            end
            OP_PROG_WORD: begin
                w_prog_ok  = w_sec_ok & w_in_sector & w_aligned
                             & ((r_mem_q & r_data) == r_data);
                w_new_word = r_data;
                w_ok       = w_prog_ok;
            end
            OP_ERASE: begin
                w_ok = w_sec_ok;
            end
            OP_SIZE: begin
                w_ok = (w_run <= SW'(NUM_SECTORS));
                if (w_ok) begin
                    w_ans = (w_size > 32'(ANSWER_MAX)) ? ANSWER_MAX : w_size[ANSWER_W-1:0];
                end
            end
            OP_FIND: begin
                w_ans = w_found[ANSWER_W-1:0];
                w_ok  = (w_found < (OFFSET_W + 1)'(NUM_SECTORS));
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    // single write port: reset sweep, sector erase or program write-back
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_addr;
        w_wr_data = r_data;
        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr;
                w_wr_data = ERASED_WORD;
            end
            S_ERASE: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_base + AW'(r_epos);
                w_wr_data = ERASED_WORD;
            end
            S_EXEC: begin
                w_wr_en   = w_out_load & w_prog_ok;
                w_wr_addr = r_addr;
                w_wr_data = w_new_word;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    // array memory, read issued on acceptance
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_accept) begin
            r_mem_q <= r_mem[w_idx_full[AW-1:0]];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_epos      = r_epos;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(ARRAY_WORDS - 1)) begin
                    n_clr   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_epos = '0;
                    case (i_op)
                        OP_ERASE: n_state = w_sec_ok_in ? S_ERASE : S_EXEC;
                        OP_FIND:  n_state = S_DIV;
                        default:  n_state = S_EXEC;
                    endcase
                end
            end
            S_ERASE: begin
                n_epos = r_epos + 1'b1;
                if (r_epos == EW'(WPS - 1)) begin
                    n_epos  = '0;
                    n_state = S_EXEC;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_epos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_epos      <= n_epos;
            r_out_valid <= n_out_valid;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_op;
            r_sector <= i_sector;
            r_offset <= i_offset;
            r_count  <= i_count;
            r_data   <= i_data;
            r_addr   <= w_idx_full[AW-1:0];
            r_base   <= w_base_full[AW-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_ok  <= w_ok;
            r_rd  <= w_rd;
            r_ans <= w_ans;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_read_data = r_rd;
    assign o_answer    = r_ans;

endmodule

### rtl/nfa_div.sv
// ----------------------------------------------------------------------------
// nfa_div
// Division of a byte offset by a fixed divisor through a reciprocal multiply.
// The quotient and done are both registered on the start pulse.
// ----------------------------------------------------------------------------
module nfa_div #(
    parameter int DIVISOR = nfa_pkg::SECTOR_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [nfa_pkg::OFFSET_W-1:0] i_dividend,
    output logic                         o_done,
    output logic [nfa_pkg::OFFSET_W-1:0] o_quotient
);
    import nfa_pkg::*;

    // q = (n * RECIP) >> SHIFT is exact for every OFFSET_W-bit n when
    // SHIFT = OFFSET_W + clog2(DIVISOR) and RECIP = ceil(2^SHIFT / DIVISOR)
    localparam int     SHIFT      = OFFSET_W + $clog2(DIVISOR);
    localparam int     RW         = OFFSET_W + 1;
    localparam int     PW         = OFFSET_W + RW;
    localparam longint RECIP_FULL = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                                    / longint'(DIVISOR);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);

    logic                r_done;
    logic [OFFSET_W-1:0] r_quo;
    logic [PW-1:0]       w_prod;

    assign w_prod = PW'(i_dividend) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= OFFSET_W'(w_prod >> SHIFT);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/nfa_checker.sv
// ----------------------------------------------------------------------------
// nfa_checker
// Port-level checks for the NOR flash array model, bound to the top level.
// ----------------------------------------------------------------------------
module nfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_ok,
    input logic [31:0] o_read_data,
    input logic [15:0] o_answer
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_ok) && $stable(o_read_data) && $stable(o_answer))
        else $error("result word changed while stalled");

    // one request at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while previous one in progress");

    // read data only on a successful read
    a_rd_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_read_data == 32'h0)
        else $error("read data on a failed request");

    // a read result carries no answer
    a_rd_no_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_data != 32'h0) |-> o_answer == 16'h0)
        else $error("answer on a read result");

endmodule

bind nor_flash_array_model_core nfa_checker u_nfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_ok        (o_ok),
    .o_read_data (o_read_data),
    .o_answer    (o_answer)
);

### test/tb_nor_flash_array_model_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nor_flash_array_model_core
// Self-checking bench for the NOR flash array core. A directed table covers
// range, alignment and cleared-bit errors, erase, size and find, then random
// requests, mostly well-formed, are scored against a local array model under
// three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_nor_flash_array_model_core;
    import nfa_pkg::*;

    localparam int NUM_SECTORS      = NUM_SECTORS_DEF;
    localparam int SECTOR_BYTES     = SECTOR_BYTES_DEF;
    localparam int WORDS_PER_SECTOR = SECTOR_BYTES / 4;
    localparam int ARRAY_WORDS      = NUM_SECTORS * WORDS_PER_SECTOR;
    localparam int STALL_LIMIT      = 8000;
    localparam int TAIL_CYCLES      = 2 * WORDS_PER_SECTOR + 40;
    localparam int DIR_N            = 26;

    // Op codes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SECTOR_W-1:0] sector;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  count;
        logic [WORD_W-1:0]   data;
    } t_flash_req;

    typedef struct packed {
        logic                ok;
        logic [WORD_W-1:0]   read_data;
        logic [ANSWER_W-1:0] answer;
    } t_flash_res;

    typedef struct packed {
        t_flash_req req;
        logic       typed;
        t_flash_res res;
    } t_dir_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_op        = '0;
    logic [SECTOR_W-1:0] i_sector    = '0;
    logic [OFFSET_W-1:0] i_offset    = '0;
    logic [COUNT_W-1:0]  i_count     = '0;
    logic [WORD_W-1:0]   i_data      = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_ok;
    logic [WORD_W-1:0]   o_read_data;
    logic [ANSWER_W-1:0] o_answer;

    // Side-band for the word in flight: a hand-typed result, if any
    logic       row_typed = 1'b0;
    t_flash_res row_exp   = '0;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned mismatches  = 0;
    int unsigned quiet_cycles = 0;

    logic [WORD_W-1:0] flash_mem [ARRAY_WORDS];
    t_flash_res        pending_results [$];

    // Directed table: typed results only where obvious
    t_dir_row dir_rows [DIR_N] = '{
        '{'{OP_READ,      8'd0,   16'd0,     8'd0,   32'h0},        1'b1,
          '{1'b1, ERASED_WORD, 16'd0}},
        '{'{OP_READ,      8'd15,  16'd252,   8'd0,   32'h0},        1'b1,
          '{1'b1, ERASED_WORD, 16'd0}},
        '{'{OP_READ,      8'd16,  16'd0,     8'd0,   32'h0},        1'b1, '0},
        '{'{OP_READ,      8'd255, 16'hFFFF,  8'd255, 32'hFFFF_FFFF}, 1'b1, '0},
        '{'{OP_READ,      8'd0,   16'd2,     8'd0,   32'h0},        1'b1, '0},
        '{'{OP_PROG_WORD, 8'd0,   16'd0,     8'd0,   32'h1234_5678}, 1'b1,
          '{1'b1, 32'h0, 16'd0}},
        '{'{OP_PROG_WORD, 8'd0,   16'd0,     8'd0,   32'hFFFF_FFFF}, 1'b1, '0},
        '{'{OP_READ,      8'd0,   16'd0,     8'd0,   32'h0},        1'b0, '0},
        '{'{OP_PROG_BYTE, 8'd0,   16'd3,     8'd0,   32'hFFFF_FF00}, 1'b0, '0},
        '{'{OP_READ,      8'd0,   16'd0,     8'd0,   32'h0},        1'b0, '0},
        '{'{OP_PROG_BYTE, 8'd1,   16'd255,   8'd0,   32'h0000_00A5}, 1'b0, '0},
        '{'{OP_PROG_BYTE, 8'd1,   16'd255,   8'd0,   32'h0000_005A}, 1'b0, '0},
        '{'{OP_PROG_BYTE, 8'd0,   16'd256,   8'd0,   32'h0},        1'b1, '0},
        '{'{OP_PROG_WORD, 8'd2,   16'd1,     8'd0,   32'h0},        1'b1, '0},
        '{'{OP_PROG_WORD, 8'd16,  16'd0,     8'd0,   32'h0},        1'b1, '0},
        '{'{OP_ERASE,     8'd0,   16'd0,     8'd0,   32'h0},        1'b1,
          '{1'b1, 32'h0, 16'd0}},
        '{'{OP_READ,      8'd0,   16'd0,     8'd0,   32'h0},        1'b1,
          '{1'b1, ERASED_WORD, 16'd0}},
        '{'{OP_ERASE,     8'd255, 16'd0,     8'd0,   32'h0},        1'b1, '0},
        '{'{OP_SIZE,      8'd0,   16'd0,     8'd16,  32'h0},        1'b1,
          '{1'b1, 32'h0, 16'(NUM_SECTORS * SECTOR_BYTES)}},
        '{'{OP_SIZE,      8'd0,   16'd0,     8'd0,   32'h0},        1'b1,
          '{1'b1, 32'h0, 16'd0}},
        '{'{OP_SIZE,      8'd15,  16'd0,     8'd2,   32'h0},        1'b1, '0},
        '{'{OP_FIND,      8'd0,   16'hFFFF,  8'd0,   32'h0},        1'b1,
          '{1'b0, 32'h0, 16'(NUM_SECTORS)}},
        '{'{OP_FIND,      8'd3,   16'd512,   8'd0,   32'h0},        1'b0, '0},
        '{'{OP_FIND,      8'd200, 16'd0,     8'd0,   32'h0},        1'b1,
          '{1'b0, 32'h0, 16'd200}},
        '{'{OP_SPARE_6,   8'd1,   16'd4,     8'd1,   32'h0},        1'b1, '0},
        '{'{OP_SPARE_7,   8'd2,   16'd8,     8'd3,   32'hFFFF_FFFF}, 1'b1, '0}
    };

    nor_flash_array_model_core #(
        .NUM_SECTORS  (NUM_SECTORS),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_sector    (i_sector),
        .i_offset    (i_offset),
        .i_count     (i_count),
        .i_data      (i_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ok        (o_ok),
        .o_read_data (o_read_data),
        .o_answer    (o_answer)
    );

    always #1 i_clk = ~i_clk;

    // Apply one request to the local array and give its result
    function automatic t_flash_res flash_apply(t_flash_req req);
        t_flash_res  res;
        int unsigned sec, off, idx, sh, run;
        logic [7:0]  cur_byte, new_byte;
        res = '0;
        sec = req.sector;
        off = req.offset;
        idx = sec * WORDS_PER_SECTOR + (off >> 2);
        case (req.op)
            OP_READ: begin
                if (sec < NUM_SECTORS && off + 4 <= SECTOR_BYTES && off % 4 == 0) begin
                    res.ok        = 1'b1;
                    res.read_data = flash_mem[idx];
                end
            end
            OP_PROG_BYTE: begin
                if (sec < NUM_SECTORS && off + 1 <= SECTOR_BYTES) begin
                    sh       = (off % 4) * 8;
                    cur_byte = 8'(flash_mem[idx] >> sh);
                    new_byte = req.data[7:0];
                    if ((cur_byte & new_byte) == new_byte) begin
                        flash_mem[idx] = (flash_mem[idx] & ~({24'h0, BYTE_MASK} << sh))
                                       | ({24'h0, new_byte} << sh);
                        res.ok = 1'b1;
                    end
                end
            end
            OP_PROG_WORD: begin
                if (sec < NUM_SECTORS && off + 4 <= SECTOR_BYTES && off % 4 == 0) begin
                    if ((flash_mem[idx] & req.data) == req.data) begin
                        flash_mem[idx] = req.data;
                        res.ok         = 1'b1;
                    end
                end
            end
            OP_ERASE: begin
                if (sec < NUM_SECTORS) begin
                    for (int w = 0; w < WORDS_PER_SECTOR; w++)
                        flash_mem[sec * WORDS_PER_SECTOR + w] = ERASED_WORD;
                    res.ok = 1'b1;
                end
            end
            OP_SIZE: begin
                if (sec + req.count <= NUM_SECTORS) begin
                    run        = req.count * SECTOR_BYTES;
                    res.ok     = 1'b1;
                    res.answer = (run > ANSWER_MAX) ? ANSWER_MAX : 16'(run);
                end
            end
            OP_FIND: begin
                if (sec < NUM_SECTORS) begin
                    run        = sec + off / SECTOR_BYTES;
                    res.answer = (run > NUM_SECTORS) ? 16'(NUM_SECTORS) : 16'(run);
                end else begin
                    res.answer = 16'(sec);
                end
                res.ok = (res.answer < NUM_SECTORS);
            end
            default: ;
        endcase
        return res;
    endfunction

    // Random request: mostly in-range with programs biased to succeed
    function automatic t_flash_req random_request();
        t_flash_req  req;
        int unsigned pick, idx;
        logic [7:0]  cur_byte;
        req.op     = 3'($urandom_range(0, 7));
        req.sector = 8'($urandom);
        req.offset = 16'($urandom);
        req.count  = 8'($urandom);
        req.data   = $urandom;
        if ($urandom_range(0, 99) < 20)
            return req;
        pick       = $urandom_range(0, 99);
        req.sector = 8'($urandom_range(0, NUM_SECTORS - 1));
        if (pick < 25) begin
            req.op     = OP_READ;
            req.offset = 16'($urandom_range(0, WORDS_PER_SECTOR - 1) * 4);
        end else if (pick < 50) begin
            req.op     = OP_PROG_WORD;
            req.offset = 16'($urandom_range(0, WORDS_PER_SECTOR - 1) * 4);
            idx        = req.sector * WORDS_PER_SECTOR + (req.offset >> 2);
            if ($urandom_range(0, 99) < 70)
                req.data = flash_mem[idx] & $urandom;
        end else if (pick < 75) begin
            req.op     = OP_PROG_BYTE;
            req.offset = 16'($urandom_range(0, SECTOR_BYTES - 1));
            idx        = req.sector * WORDS_PER_SECTOR + (req.offset >> 2);
            cur_byte   = 8'(flash_mem[idx] >> ((req.offset % 4) * 8));
            if ($urandom_range(0, 99) < 70)
                req.data[7:0] = cur_byte & req.data[7:0];
        end else if (pick < 82) begin
            req.op = OP_ERASE;
        end else if (pick < 91) begin
            req.op    = OP_SIZE;
            req.count = 8'($urandom_range(0, NUM_SECTORS - req.sector + 1));
        end else begin
            req.op     = OP_FIND;
            req.offset = 16'($urandom_range(0, NUM_SECTORS * SECTOR_BYTES));
        end
        return req;
    endfunction

    // Present one request word and hold it until taken
    task automatic send_request(input t_flash_req req, input logic typed,
                                input t_flash_res res);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= req.op;
        i_sector   <= req.sector;
        i_offset   <= req.offset;
        i_count    <= req.count;
        i_data     <= req.data;
        row_typed  <= typed;
        row_exp    <= res;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Hold off new requests until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Receiver back-pressure
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Predict on request accept, score on result accept
    always @(posedge i_clk) begin : result_check
        t_flash_res pred, exp_res;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pred = flash_apply('{i_op, i_sector, i_offset, i_count, i_data});
            pending_results.push_back(row_typed ? row_exp : pred);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected (ok %0b data %h answer %h)",
                         $time, o_ok, o_read_data, o_answer);
                mismatches++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_ok !== exp_res.ok) begin
                    $display("%0t: ok expected %0b actual %0b", $time, exp_res.ok, o_ok);
                    mismatches++;
                end
                if (o_read_data !== exp_res.read_data) begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, exp_res.read_data, o_read_data);
                    mismatches++;
                end
                if (o_answer !== exp_res.answer) begin
                    $display("%0t: answer expected %h actual %h",
                             $time, exp_res.answer, o_answer);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        for (int w = 0; w < ARRAY_WORDS; w++)
            flash_mem[w] = ERASED_WORD;
        tx_idle_pct = 19;
        rx_idle_pct = 50;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int r = 0; r < DIR_N; r++)
            send_request(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].res);

        // Random, sender idles lightly, receiver heavily
        for (int n = 0; n < 185; n++)
            send_request(random_request(), 1'b0, '0);
        drain_results();

        // Random, roles swapped
        tx_idle_pct = 50;
        rx_idle_pct = 19;
        for (int n = 0; n < 185; n++)
            send_request(random_request(), 1'b0, '0);
        drain_results();

        // Random, full rate both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int n = 0; n < 180; n++)
            send_request(random_request(), 1'b0, '0);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/nfa_pkg.sv
rtl/nfa_div.sv
rtl/nor_flash_array_model_core.sv
rtl/nfa_checker.sv
test/tb_nor_flash_array_model_core.sv
